### hdl/nrle_pkg.sv
// shared types and constants of the nibble run-length encoder
`timescale 1ns / 1ps
`default_nettype none
package nrle_pkg;

    localparam int unsigned PIXEL_W  = 8;
    localparam int unsigned COLOUR_W = 4;
    localparam int unsigned LEN_W    = 10;
    localparam int unsigned BYTE_W   = 8;

    localparam logic [LEN_W-1:0] MAX_RUN_RESET = LEN_W'(1023);
    localparam logic [LEN_W-1:0] SHORT_RUN_LIMIT = LEN_W'(8);

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               end_of_image;
    } pix_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] code_byte;
        logic              last_byte;
    } code_out_t;

    typedef struct packed {
        logic [COLOUR_W-1:0] colour;
        logic [LEN_W-1:0]    len;
    } run_t;

    // runs closed by one pixel: the run it ends, then the run that end_of_image flushes
    typedef struct packed {
        logic a_valid;
        run_t a;
        logic b_valid;
        run_t b;
    } run_req_t;

endpackage
`default_nettype wire

### hdl/nrle_front.sv
// front end: run tracking and closed-run requests
`timescale 1ns / 1ps
`default_nettype none
module nrle_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire nrle_pkg::pix_in_t in_data,
    input  wire logic             cfg_wr_en,
    input  wire logic [nrle_pkg::LEN_W-1:0] cfg_wr_data,
    input  wire logic             q_full,
    output logic                  q_push,
    output nrle_pkg::run_req_t    q_data
);
    import nrle_pkg::*;

    logic [LEN_W-1:0]    max_run_reg;
    logic                run_open_reg, run_open_next;
    logic [COLOUR_W-1:0] run_colour_reg, run_colour_next;
    logic [LEN_W-1:0]    run_count_reg, run_count_next;
    logic [COLOUR_W-1:0] colour;
    logic                extend;
    logic                accept;
    logic [COLOUR_W-1:0] new_colour;
    logic [LEN_W-1:0]    new_count;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign colour   = in_data.pixel[PIXEL_W-1 -: COLOUR_W];
    assign extend   = run_open_reg && (colour == run_colour_reg)
                      && (run_count_reg < max_run_reg);

    always_comb
    begin
        if (extend)
        begin
            new_colour = run_colour_reg;
            new_count  = run_count_reg + LEN_W'(1);
        end
        else
        begin
            new_colour = colour;
            new_count  = LEN_W'(1);
        end

        q_data.a_valid  = run_open_reg && !extend;
        q_data.a.colour = run_colour_reg;
        q_data.a.len    = run_count_reg;
        q_data.b_valid  = in_data.end_of_image;
        q_data.b.colour = new_colour;
        q_data.b.len    = new_count;
        q_push          = accept && (q_data.a_valid || q_data.b_valid);

        run_open_next   = run_open_reg;
        run_colour_next = run_colour_reg;
        run_count_next  = run_count_reg;
        if (accept)
        begin
            if (in_data.end_of_image)
            begin
                run_open_next   = 1'b0;
                run_colour_next = '0;
                run_count_next  = '0;
            end
            else
            begin
                run_open_next   = 1'b1;
                run_colour_next = new_colour;
                run_count_next  = new_count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_run_reg    <= MAX_RUN_RESET;
            run_open_reg   <= 1'b0;
            run_colour_reg <= '0;
            run_count_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_run_reg <= cfg_wr_data;
            end
            run_open_reg   <= run_open_next;
            run_colour_reg <= run_colour_next;
            run_count_reg  <= run_count_next;
        end
    end

endmodule
`default_nettype wire

### hdl/nrle_queue.sv
// short request queue between front end and byte packer
`timescale 1ns / 1ps
`default_nettype none
module nrle_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire nrle_pkg::run_req_t push_data,
    input  wire logic               pop,
    output logic                    full,
    output logic                    head_valid,
    output nrle_pkg::run_req_t      head_data
);
    import nrle_pkg::*;

    // depth of at least 2
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    run_req_t           store [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

### hdl/nrle_back.sv
// back end: turns run requests into code bytes, one per cycle while the output is not stalled
`timescale 1ns / 1ps
`default_nettype none
module nrle_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    input  wire nrle_pkg::run_req_t q_data,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output nrle_pkg::code_out_t     out_data
);
    import nrle_pkg::*;

    logic [1:0]        idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    code_out_t         out_data_reg, out_data_next;
    logic [2:0]        na, nb, total;
    logic [2:0]        pos;
    logic [BYTE_W-1:0] cur_byte;
    logic              is_last;
    logic              take;

    function automatic logic [2:0] run_bytes(input logic v, input run_t r);
        if (!v)
        begin
            run_bytes = 3'd0;
        end
        else if (r.len < SHORT_RUN_LIMIT)
        begin
            run_bytes = 3'd1;
        end
        else
        begin
            run_bytes = 3'd2;
        end
    endfunction

    // byte p of a run's code, long codes low byte first
    function automatic logic [BYTE_W-1:0] run_byte(input run_t r, input logic p);
        if (r.len < SHORT_RUN_LIMIT)
        begin
            run_byte = {r.colour, r.len[2:0], 1'b1};
        end
        else if (!p)
        begin
            run_byte = {r.len[5:0], 2'b10};
        end
        else
        begin
            run_byte = {r.colour, r.len[9:6]};
        end
    endfunction

    assign na    = run_bytes(q_data.a_valid, q_data.a);
    assign nb    = run_bytes(q_data.b_valid, q_data.b);
    assign total = na + nb;

    always_comb
    begin
        pos = '0;
        if ({1'b0, idx_reg} < na)
        begin
            cur_byte = run_byte(q_data.a, idx_reg[0]);
        end
        else
        begin
            pos      = {1'b0, idx_reg} - na;
            cur_byte = run_byte(q_data.b, pos[0]);
        end
    end

    assign is_last = ({1'b0, idx_reg} == total - 3'd1);
    assign take    = q_valid && (!out_valid_reg || out_ready);
    assign q_pop   = take && is_last;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (take)
        begin
            out_valid_next          = 1'b1;
            out_data_next.code_byte = cur_byte;
            out_data_next.last_byte = is_last;
            idx_next                = is_last ? 2'd0 : idx_reg + 2'd1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

### hdl/nibble_run_length_encoder_top.sv
// top level of the nibble run-length encoder
//
//  channel   direction  handshake            payload
//  in        sink       in_valid/in_ready    pix_in_t   {pixel, end_of_image}
//  out       source     out_valid/out_ready  code_out_t {code_byte, last_byte}
//  cfg       sink       cfg_wr_en            cfg_wr_data = max_run_length
//
// a pixel is taken every cycle while the run queue has room; one request per
// closed-run event goes into the queue of QUEUE_DEPTH entries
// the byte packer sends one code byte per cycle while out_ready holds; a request
// gives 1 to 4 bytes, and the output byte rate sets the sustained pixel rate
// when runs are short; a request waits in the queue, its bytes in the output register;
// reset clears run state, queue and output valid, and max_run_length returns to 1023
`timescale 1ns / 1ps
`default_nettype none
module nibble_run_length_encoder_top #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire nrle_pkg::pix_in_t          in_data,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output nrle_pkg::code_out_t             out_data,
    input  wire logic                       cfg_wr_en,
    input  wire logic [nrle_pkg::LEN_W-1:0] cfg_wr_data
);
    import nrle_pkg::*;

    logic     q_full;
    logic     q_push;
    logic     q_pop;
    logic     q_valid;
    run_req_t q_in;
    run_req_t q_head;

    nrle_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_in)
    );

    nrle_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .head_valid(q_valid),
        .head_data (q_head)
    );

    nrle_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (q_head),
        .q_pop    (q_pop),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

endmodule
`default_nettype wire

### hdl/nrle_checker.sv
// port-level checks of the encoder and their binding
`timescale 1ns / 1ps
`default_nettype none
module nrle_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire nrle_pkg::code_out_t out_data
);
    import nrle_pkg::*;

    logic in_acc;

    assign in_acc = in_valid && in_ready;

    // a stalled code byte stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("out_data changed while stalled");

    // the rest of a request's bytes follow without a gap
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_byte |=> out_valid)
        else $error("gap inside a code byte burst");

    // no code byte appears without a recent pixel request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !in_acc && !$past(in_acc) |=> !out_valid)
        else $error("code byte without a pixel request");

endmodule

bind nibble_run_length_encoder_top nrle_checker u_nrle_checker (.*);
`default_nettype wire

### sim/tb.sv
// self-checking testbench of the nibble run-length encoder
`timescale 1ns / 1ps
module tb;
    import nrle_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    pix_in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    code_out_t out_data;
    logic cfg_wr_en = 1'b0;
    logic [LEN_W-1:0] cfg_wr_data = '0;

    pix_in_t pixel_queue[$];
    code_out_t want_codes[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int err_count = 0;
    int cycle_count = 0;

    // encoder state as the block should hold it
    logic have_run = 1'b0;
    logic [COLOUR_W-1:0] cur_colour = '0;
    logic [LEN_W-1:0] cur_len = '0;
    logic [LEN_W-1:0] run_limit = MAX_RUN_RESET;

    nibble_run_length_encoder_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // short runs take one byte, long runs a 16-bit word sent low byte first
    function automatic void push_run(input logic [COLOUR_W-1:0] colour,
                                     input logic [LEN_W-1:0] len);
        code_out_t c;
        logic [15:0] word;
        c.last_byte = 1'b0;
        if (len < SHORT_RUN_LIMIT)
        begin
            c.code_byte = {colour, len[2:0], 1'b1};
            want_codes.insert(want_codes.size(), c);
        end
        else
        begin
            word = {colour, len, 2'b10};
            c.code_byte = word[7:0];
            want_codes.insert(want_codes.size(), c);
            c.code_byte = word[15:8];
            want_codes.insert(want_codes.size(), c);
        end
    endfunction

    function automatic void encode_pixel(input pix_in_t p);
        logic [COLOUR_W-1:0] colour;
        int start_size;
        colour = p.pixel[PIXEL_W-1 -: COLOUR_W];
        start_size = want_codes.size();
        if (have_run && colour == cur_colour && cur_len < run_limit)
            cur_len = cur_len + 1'b1;
        else
        begin
            if (have_run)
                push_run(cur_colour, cur_len);
            have_run = 1'b1;
            cur_colour = colour;
            cur_len = LEN_W'(1);
        end
        if (p.end_of_image)
        begin
            push_run(cur_colour, cur_len);
            have_run = 1'b0;
            cur_colour = '0;
            cur_len = '0;
        end
        if (want_codes.size() > start_size)
            want_codes[want_codes.size() - 1].last_byte = 1'b1;
    endfunction

    // driver: takes the next pending request once the slot is free
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_data <= pixel_queue.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor: predicts on accepted pixels, checks accepted code bytes
    always @(posedge clk)
    begin
        code_out_t exp_code;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (out_valid && out_ready)
            begin
                if (want_codes.size() == 0)
                begin
                    $display("%0t: unexpected code byte, expected none, got %h last %b",
                             $time, out_data.code_byte, out_data.last_byte);
                    err_count++;
                end
                else
                begin
                    exp_code = want_codes.pop_front();
                    if (out_data.code_byte !== exp_code.code_byte)
                    begin
                        $display("%0t: code_byte mismatch, expected %h, got %h",
                                 $time, exp_code.code_byte, out_data.code_byte);
                        err_count++;
                    end
                    if (out_data.last_byte !== exp_code.last_byte)
                    begin
                        $display("%0t: last_byte mismatch, expected %b, got %b",
                                 $time, exp_code.last_byte, out_data.last_byte);
                        err_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                encode_pixel(in_data);
        end
    end

    function automatic void push_pixel(input logic [PIXEL_W-1:0] pixel, input logic eoi);
        pix_in_t p;
        p.pixel = pixel;
        p.end_of_image = eoi;
        pixel_queue.insert(pixel_queue.size(), p);
    endfunction

    // mostly runs of one colour with random low nibbles, some long, some single pixels
    function automatic void queue_random_pixels(input int count);
        logic [COLOUR_W-1:0] colour;
        int n;
        int len;
        n = 0;
        while (n < count)
        begin
            colour = COLOUR_W'($urandom_range(15));
            if ($urandom_range(4) == 0)
                len = 1;
            else if ($urandom_range(9) == 0)
                len = $urandom_range(13, 24);
            else
                len = $urandom_range(1, 12);
            for (int k = 0; k < len && n < count; k++)
            begin
                push_pixel({colour, 4'($urandom_range(15))},
                           (n == count - 1) || ($urandom_range(19) == 0));
                n++;
            end
        end
    endfunction

    task automatic wait_drained();
        @(negedge clk);
        while (pixel_queue.size() != 0 || in_valid || want_codes.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_run_limit(input logic [LEN_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        run_limit = value;
    endtask

    initial
    begin
        logic [LEN_W-1:0] limits[8];
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: single-pixel images at both extremes
        push_pixel(8'h00, 1'b1);
        push_pixel(8'hFF, 1'b1);
        // run of seven then a colour change, last pixel flushes the new run
        for (int k = 0; k < 7; k++)
            push_pixel(8'h50 | 8'(k * 2), 1'b0);
        push_pixel(8'hC3, 1'b0);
        push_pixel(8'hC4, 1'b1);
        // run of eight needs the two-byte form, then change plus end of image
        for (int k = 0; k < 8; k++)
            push_pixel(8'hA0 | 8'(k), 1'b0);
        push_pixel(8'h0F, 1'b1);
        wait_drained();

        // one colour over forty pixels: two full runs of sixteen, then eight flushed
        set_run_limit(LEN_W'(16));
        for (int k = 0; k < 40; k++)
            push_pixel({4'h7, 4'($urandom_range(15))}, k == 39);
        wait_drained();

        limits = '{LEN_W'(0), LEN_W'(1), LEN_W'(7), LEN_W'(8), LEN_W'(9),
                   LEN_W'(1023), LEN_W'($urandom_range(2, 20)),
                   LEN_W'($urandom_range(2, 1022))};
        for (int ph = 0; ph < 8; ph++)
        begin
            set_run_limit(limits[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            queue_random_pixels(12);
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### nibble_run_length_encoder_top.f
hdl/nrle_pkg.sv
hdl/nrle_front.sv
hdl/nrle_queue.sv
hdl/nrle_back.sv
hdl/nibble_run_length_encoder_top.sv
hdl/nrle_checker.sv
sim/tb.sv
